@@ sv/vsfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfb_pkg
// Shared types and constants for the structure function binning unit.
// ----------------------------------------------------------------------------
package vsfb_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PERIODIC_X = 3'd0;
    localparam logic [2:0] CFG_SPACING_X  = 3'd1;
    localparam logic [2:0] CFG_SPACING_Y  = 3'd2;
    localparam logic [2:0] CFG_SPACING_Z  = 3'd3;
    localparam logic [2:0] CFG_ORDER_LOW  = 3'd4;
    localparam logic [2:0] CFG_ORDER_HIGH = 3'd5;
    localparam logic [2:0] CFG_MIN_DIST   = 3'd6;

    // shift-subtract unit geometry
    localparam int UNIT_W     = 72;
    localparam int ROOT_W     = 36;
    localparam int REM_W      = 40;
    localparam int SQRT_STEPS = 36;
    localparam int DIV_STEPS  = 64;

    localparam logic UNIT_SQRT = 1'b0;
    localparam logic UNIT_DIV  = 1'b1;

    // order counter width (configured orders up to 15)
    localparam int Q_W = 5;

    typedef struct packed {
        logic start;
        logic mode;
    } t_unit_req;

endpackage

@@ sv/vsfb_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfb_mul
// Unsigned 64 x 64 multiplier built from one 32 x 32 product per cycle.
// ----------------------------------------------------------------------------
module vsfb_mul import vsfb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_opa,
    input  logic [63:0]  i_opb,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pj;
    logic         r_pv;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;

    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    assign w_pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp = w_pa * w_pb;

    always_comb begin
        unique case (r_pj)
            2'd0:    w_sh = {64'b0, r_pp};
            2'd1,
            2'd2:    w_sh = {32'b0, r_pp, 32'b0};
            default: w_sh = {r_pp, 64'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_a    <= i_opa;
                r_b    <= i_opb;
                r_acc  <= 128'b0;
                r_cnt  <= 3'd0;
                r_pv   <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp <= w_pp;
                    r_pj <= r_cnt[1:0];
                    r_pv <= 1'b1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_acc <= r_acc + w_sh;
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ sv/vsfb_digit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsfb_digit
// Shift-subtract unit: floor square root or unsigned division, one bit a cycle.
// ----------------------------------------------------------------------------
module vsfb_digit import vsfb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_req         i_req,
    input  logic [UNIT_W-1:0] i_opa,
    input  logic [ROOT_W-1:0] i_opb,
    output logic              o_done,
    output logic [63:0]       o_res,
    output logic              o_rem_nz
);

    logic              r_busy;
    logic              r_done;
    logic              r_mode;
    logic [6:0]        r_cnt;
    logic [UNIT_W-1:0] r_val;
    logic [REM_W-1:0]  r_rem;
    logic [63:0]       r_res;
    logic [ROOT_W-1:0] r_div;

    logic [REM_W-1:0]  w_cand;
    logic [REM_W-1:0]  w_trial;
    logic              w_ge;

    always_comb begin
        if (r_mode == UNIT_SQRT) begin
            w_cand  = {r_rem[REM_W-3:0], r_val[UNIT_W-1 -: 2]};
            w_trial = {2'b0, r_res[ROOT_W-1:0], 2'b01};
        end else begin
            w_cand  = {r_rem[REM_W-2:0], r_val[UNIT_W-1]};
            w_trial = {{(REM_W-ROOT_W){1'b0}}, r_div};
        end
        w_ge = (w_cand >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_mode <= i_req.mode;
                r_val  <= i_opa;
                r_div  <= i_opb;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= (i_req.mode == UNIT_SQRT) ? 7'(SQRT_STEPS) : 7'(DIV_STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_cand - w_trial) : w_cand;
                r_res <= {r_res[62:0], w_ge};
                r_val <= (r_mode == UNIT_SQRT) ? (r_val << 2) : (r_val << 1);
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_res    = r_res;
    assign o_rem_nz = (r_rem != '0);

endmodule

@@ sv/vector_structure_function_binning_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_structure_function_binning_unit
// Bins longitudinal and transverse velocity difference powers by separation.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_axis   | in        | two cell index triples and two velocity vectors
//  m_axis   | out       | one bin update per order, tlast on the final order
//  cfg      | in        | register index and write data
//
// After reset a clearing pass over all RADIUS_BINS*(MAX_ORDER+1) entries (576 by
// default) zeroes the sums and counts; no beat is taken meanwhile.
// A pair's setup runs on the shared 64x64 multiplier and the shift-subtract
// unit (two roots of 36 steps, one division of 64 steps); each order is then
// raised, read, accumulated and sent out in turn.
// Skipped pairs finish early. A result waits in its output register until
// taken; the block holds until then.
module vector_structure_function_binning_unit import vsfb_pkg::*; #(
    parameter int GRID_X      = 256,
    parameter int GRID_Y      = 256,
    parameter int GRID_Z      = 256,
    parameter int RADIUS_BINS = 64,
    parameter int MAX_ORDER   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // first_vel_x/y/z, second_vel_x/y/z
    input  logic [239:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // radius_bin, order, parallel_sum, perpendicular_sum, pair_count, zero pad
    output logic [175:0] o_m_tdata,
    // saturated
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_data
);

    localparam int NORD   = MAX_ORDER + 1;
    localparam int NSUM   = RADIUS_BINS * NORD;
    localparam int SUM_AW = $clog2(NSUM);
    localparam int CNT_AW = $clog2(RADIUS_BINS);
    localparam int C_W    = CNT_AW + 16;
    localparam logic [63:0] RB_LIM = 64'(RADIUS_BINS) << 16;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_MWAIT   = 4'd3;
    localparam logic [3:0] S_ROOT_S  = 4'd4;
    localparam logic [3:0] S_ROOT_SW = 4'd5;
    localparam logic [3:0] S_DIV     = 4'd6;
    localparam logic [3:0] S_DIVW    = 4'd7;
    localparam logic [3:0] S_ROOT_R  = 4'd8;
    localparam logic [3:0] S_ROOT_RW = 4'd9;
    localparam logic [3:0] S_ORD     = 4'd10;
    localparam logic [3:0] S_RD      = 4'd11;
    localparam logic [3:0] S_ACC     = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    localparam logic [2:0] PH_C  = 3'd0;
    localparam logic [2:0] PH_CC = 3'd1;
    localparam logic [2:0] PH_VV = 3'd2;
    localparam logic [2:0] PH_VC = 3'd3;
    localparam logic [2:0] PH_MD = 3'd4;
    localparam logic [2:0] PH_P2 = 3'd5;
    localparam logic [2:0] PH_PW = 3'd6;
    localparam logic [2:0] PH_PT = 3'd7;

    localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN  = 64'h8000_0000_0000_0000;

    function automatic logic signed [15:0] wrap_sep(input logic [7:0] a,
                                                     input logic [7:0] b,
                                                     input logic signed [15:0] grid,
                                                     input logic wrap);
        logic signed [15:0] d;
        logic signed [15:0] half;
        d    = signed'({8'b0, b}) - signed'({8'b0, a});
        half = grid >>> 1;
        if (wrap && (d > half)) begin
            d = d - grid;
        end else if (wrap && (d < -half)) begin
            d = d + grid;
        end
        return d;
    endfunction

    // configuration
    logic        r_per_x;
    logic [23:0] r_spx;
    logic [23:0] r_spy;
    logic [23:0] r_spz;
    logic [3:0]  r_olow;
    logic [3:0]  r_ohigh;
    logic [15:0] r_mind;

    // sequencer
    logic [3:0]        r_state;
    logic [2:0]        r_ph;
    logic [1:0]        r_i;
    logic [SUM_AW-1:0] r_clr;

    // item working set
    logic [7:0]         r_fx, r_fy, r_fz, r_sx, r_sy, r_sz;
    logic signed [32:0] r_dv0, r_dv1, r_dv2;
    logic [C_W-1:0]     r_c0, r_c1, r_c2;
    logic [2:0]         r_cneg;
    logic [63:0]        r_s;
    logic [71:0]        r_n2;
    logic signed [63:0] r_dot;
    logic [ROOT_W-1:0]  r_d;
    logic [CNT_AW-1:0]  r_k;
    logic [SUM_AW-1:0]  r_base;
    logic [63:0]        r_pll_mag;
    logic               r_pll_neg;
    logic [71:0]        r_rad;
    logic [63:0]        r_perp;
    logic [Q_W-1:0]     r_q;
    logic [Q_W-1:0]     r_hi;
    logic [Q_W-1:0]     r_pq;
    logic [63:0]        r_mpll;
    logic [63:0]        r_mperp;
    logic               r_sat_pll;
    logic               r_sat_perp;
    logic signed [63:0] r_pp_s;
    logic signed [63:0] r_pt_s;

    // stores
    logic [127:0] r_sum_mem [NSUM];
    logic [31:0]  r_cnt_mem [RADIUS_BINS];
    logic [127:0] r_rd_sum;
    logic [31:0]  r_rd_cnt;

    // output register
    logic         r_out_valid;
    logic [175:0] r_out_data;
    logic         r_out_sat;
    logic         r_out_last;

    // shared units
    logic               w_mstart;
    logic [63:0]        w_ma;
    logic [63:0]        w_mb;
    logic               w_mdone;
    logic [127:0]       w_prod;
    t_unit_req          w_ureq;
    logic [UNIT_W-1:0]  w_uopa;
    logic               w_udone;
    logic [63:0]        w_ures;
    logic               w_urem_nz;

    // helpers
    logic signed [15:0] w_sep;
    logic [15:0]        w_sep_mag;
    logic [23:0]        w_sp;
    logic [C_W-1:0]     w_c_cur;
    logic signed [32:0] w_dv_cur;
    logic [32:0]        w_dv_mag;
    logic [63:0]        w_dot_mag;
    logic [36:0]        w_kraw;
    logic [Q_W-1:0]     w_hi;
    logic [SUM_AW-1:0]  w_addr;
    logic               w_sum_we;
    logic [SUM_AW-1:0]  w_sum_wa;
    logic [127:0]       w_sum_wd;
    logic               w_cnt_we;
    logic [CNT_AW-1:0]  w_cnt_wa;
    logic [31:0]        w_cnt_wd;
    logic [63:0]        w_old_p, w_old_t, w_sum_p, w_sum_t, w_new_p, w_new_t;
    logic               w_ovf_p, w_ovf_t, w_cnt_max;
    logic [31:0]        w_cnt_new;
    logic [15:0]        w_k_ext;
    logic [63:0]        w_pow_next;
    logic               w_pow_ovf;

    always_comb begin
        unique case (r_i)
            2'd0: begin
                w_sep    = wrap_sep(r_fx, r_sx, 16'(GRID_X), r_per_x);
                w_sp     = r_spx;
                w_c_cur  = r_c0;
                w_dv_cur = r_dv0;
            end
            2'd1: begin
                w_sep    = wrap_sep(r_fy, r_sy, 16'(GRID_Y), 1'b1);
                w_sp     = r_spy;
                w_c_cur  = r_c1;
                w_dv_cur = r_dv1;
            end
            default: begin
                w_sep    = wrap_sep(r_fz, r_sz, 16'(GRID_Z), 1'b1);
                w_sp     = r_spz;
                w_c_cur  = r_c2;
                w_dv_cur = r_dv2;
            end
        endcase
        w_sep_mag = w_sep[15] ? 16'(-w_sep) : 16'(w_sep);
        w_dv_mag  = w_dv_cur[32] ? 33'(-w_dv_cur) : 33'(w_dv_cur);
        w_dot_mag = r_dot[63] ? 64'(-r_dot) : 64'(r_dot);
    end

    always_comb begin
        unique case (r_ph)
            PH_C:  begin w_ma = 64'(w_sep_mag); w_mb = 64'(w_sp);       end
            PH_CC: begin w_ma = 64'(w_c_cur);   w_mb = 64'(w_c_cur);    end
            PH_VV: begin w_ma = 64'(w_dv_mag);  w_mb = 64'(w_dv_mag);   end
            PH_VC: begin w_ma = 64'(w_dv_mag);  w_mb = 64'(w_c_cur);    end
            PH_MD: begin w_ma = 64'(r_mind);    w_mb = 64'(r_mind);     end
            PH_P2: begin w_ma = r_pll_mag;      w_mb = r_pll_mag;       end
            PH_PW: begin w_ma = r_mpll;         w_mb = r_pll_mag;       end
            PH_PT: begin w_ma = r_mperp;        w_mb = r_perp;          end
        endcase
    end

    assign w_mstart = (r_state == S_MUL);

    // power step: Q.32 times Q.16, back to Q.32, clamp when past the int64 range
    assign w_pow_ovf  = (w_prod[127:79] != '0);
    assign w_pow_next = {1'b0, w_prod[78:16]};

    always_comb begin
        w_ureq.start = (r_state == S_ROOT_S) || (r_state == S_DIV) || (r_state == S_ROOT_R);
        w_ureq.mode  = (r_state == S_DIV) ? UNIT_DIV : UNIT_SQRT;
        if (r_state == S_DIV) begin
            w_uopa = {w_dot_mag, 8'b0};
        end else if (r_state == S_ROOT_R) begin
            w_uopa = r_rad;
        end else begin
            w_uopa = {8'b0, r_s};
        end
    end

    vsfb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_opa   (w_ma),
        .i_opb   (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    vsfb_digit u_digit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_ureq),
        .i_opa    (w_uopa),
        .i_opb    (r_d),
        .o_done   (w_udone),
        .o_res    (w_ures),
        .o_rem_nz (w_urem_nz)
    );

    // bin is the ceiling of the distance: round up unless the root is exact
    assign w_kraw = ({1'b0, w_ures[ROOT_W-1:0]} + 37'(w_urem_nz) + 37'h0FFFF) >> 16;
    assign w_hi   = ({1'b0, r_ohigh} > Q_W'(MAX_ORDER)) ? Q_W'(MAX_ORDER) : {1'b0, r_ohigh};
    assign w_addr = r_base + SUM_AW'(r_q);

    // saturating accumulate
    always_comb begin
        w_old_p   = r_rd_sum[63:0];
        w_old_t   = r_rd_sum[127:64];
        w_sum_p   = w_old_p + r_pp_s;
        w_sum_t   = w_old_t + r_pt_s;
        w_ovf_p   = (w_old_p[63] == r_pp_s[63]) && (w_sum_p[63] != r_pp_s[63]);
        w_ovf_t   = (w_old_t[63] == r_pt_s[63]) && (w_sum_t[63] != r_pt_s[63]);
        w_new_p   = w_ovf_p ? (r_pp_s[63] ? NEG_MIN : POS_MAX) : w_sum_p;
        w_new_t   = w_ovf_t ? (r_pt_s[63] ? NEG_MIN : POS_MAX) : w_sum_t;
        w_cnt_max = (r_rd_cnt == 32'hFFFF_FFFF);
        w_cnt_new = w_cnt_max ? r_rd_cnt : (r_rd_cnt + 32'd1);
        w_k_ext   = 16'(r_k);
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_sum_we = 1'b1;
            w_sum_wa = r_clr;
            w_sum_wd = '0;
            w_cnt_we = (r_clr < SUM_AW'(RADIUS_BINS));
            w_cnt_wa = r_clr[CNT_AW-1:0];
            w_cnt_wd = '0;
        end else begin
            w_sum_we = (r_state == S_ACC);
            w_sum_wa = w_addr;
            w_sum_wd = {w_new_t, w_new_p};
            w_cnt_we = (r_state == S_ACC);
            w_cnt_wa = r_k;
            w_cnt_wd = w_cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            r_sum_mem[w_sum_wa] <= w_sum_wd;
        end
        if (w_cnt_we) begin
            r_cnt_mem[w_cnt_wa] <= w_cnt_wd;
        end
        if (r_state == S_RD) begin
            r_rd_sum <= r_sum_mem[w_addr];
            r_rd_cnt <= r_cnt_mem[r_k];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_x <= 1'b1;
            r_spx   <= 24'd65536;
            r_spy   <= 24'd65536;
            r_spz   <= 24'd65536;
            r_olow  <= 4'd1;
            r_ohigh <= 4'd8;
            r_mind  <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_PERIODIC_X: r_per_x <= i_cfg_data[0];
                CFG_SPACING_X:  r_spx   <= i_cfg_data;
                CFG_SPACING_Y:  r_spy   <= i_cfg_data;
                CFG_SPACING_Z:  r_spz   <= i_cfg_data;
                CFG_ORDER_LOW:  r_olow  <= i_cfg_data[3:0];
                CFG_ORDER_HIGH: r_ohigh <= i_cfg_data[3:0];
                CFG_MIN_DIST:   r_mind  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_ph        <= PH_C;
            r_i         <= 2'd0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SUM_AW'(1);
                    if (r_clr == SUM_AW'(NSUM - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_fx  <= i_s_tdata[7:0];
                        r_fy  <= i_s_tdata[15:8];
                        r_fz  <= i_s_tdata[23:16];
                        r_sx  <= i_s_tdata[31:24];
                        r_sy  <= i_s_tdata[39:32];
                        r_sz  <= i_s_tdata[47:40];
                        r_dv0 <= $signed({i_s_tdata[175], i_s_tdata[175:144]})
                               - $signed({i_s_tdata[79], i_s_tdata[79:48]});
                        r_dv1 <= $signed({i_s_tdata[207], i_s_tdata[207:176]})
                               - $signed({i_s_tdata[111], i_s_tdata[111:80]});
                        r_dv2 <= $signed({i_s_tdata[239], i_s_tdata[239:208]})
                               - $signed({i_s_tdata[143], i_s_tdata[143:112]});
                        r_s     <= '0;
                        r_n2    <= '0;
                        r_dot   <= '0;
                        r_i     <= 2'd0;
                        r_ph    <= PH_C;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mdone) begin
                        unique case (r_ph)
                            PH_C: begin
                                // drop the pair once any component reaches RADIUS_BINS, past the last bin
                                if (w_prod[63:0] >= RB_LIM) begin
                                    r_state <= S_IDLE;
                                end else begin
                                    unique case (r_i)
                                        2'd0:    r_c0 <= w_prod[C_W-1:0];
                                        2'd1:    r_c1 <= w_prod[C_W-1:0];
                                        default: r_c2 <= w_prod[C_W-1:0];
                                    endcase
                                    r_cneg[r_i] <= w_sep[15];
                                    if (r_i == 2'd2) begin
                                        r_i  <= 2'd0;
                                        r_ph <= PH_CC;
                                    end else begin
                                        r_i <= r_i + 2'd1;
                                    end
                                    r_state <= S_MUL;
                                end
                            end
                            PH_CC: begin
                                r_s     <= r_s + w_prod[63:0];
                                r_ph    <= PH_VV;
                                r_state <= S_MUL;
                            end
                            PH_VV: begin
                                r_n2    <= r_n2 + w_prod[71:0];
                                r_ph    <= PH_VC;
                                r_state <= S_MUL;
                            end
                            PH_VC: begin
                                if (w_dv_cur[32] ^ r_cneg[r_i]) begin
                                    r_dot <= r_dot - $signed(w_prod[63:0]);
                                end else begin
                                    r_dot <= r_dot + $signed(w_prod[63:0]);
                                end
                                if (r_i == 2'd2) begin
                                    r_i  <= 2'd0;
                                    r_ph <= PH_MD;
                                end else begin
                                    r_i  <= r_i + 2'd1;
                                    r_ph <= PH_CC;
                                end
                                r_state <= S_MUL;
                            end
                            PH_MD: begin
                                // drop close pairs
                                if (r_s <= w_prod[63:0]) begin
                                    r_state <= S_IDLE;
                                end else begin
                                    r_state <= S_ROOT_S;
                                end
                            end
                            PH_P2: begin
                                // clamp a negative radicand to zero
                                if (w_prod <= {56'b0, r_n2}) begin
                                    r_rad <= r_n2 - w_prod[71:0];
                                end else begin
                                    r_rad <= '0;
                                end
                                r_state <= S_ROOT_R;
                            end
                            PH_PW: begin
                                if (!r_sat_pll) begin
                                    if (w_pow_ovf) begin
                                        r_mpll    <= POS_MAX;
                                        r_sat_pll <= 1'b1;
                                    end else begin
                                        r_mpll <= w_pow_next;
                                    end
                                end
                                r_ph    <= PH_PT;
                                r_state <= S_MUL;
                            end
                            PH_PT: begin
                                if (!r_sat_perp) begin
                                    if (w_pow_ovf) begin
                                        r_mperp    <= POS_MAX;
                                        r_sat_perp <= 1'b1;
                                    end else begin
                                        r_mperp <= w_pow_next;
                                    end
                                end
                                r_pq    <= r_pq + Q_W'(1);
                                r_state <= S_ORD;
                            end
                        endcase
                    end
                end
                S_ROOT_S: begin
                    r_state <= S_ROOT_SW;
                end
                S_ROOT_SW: begin
                    if (w_udone) begin
                        if (w_kraw >= 37'(RADIUS_BINS)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_d     <= w_ures[ROOT_W-1:0];
                            r_k     <= w_kraw[CNT_AW-1:0];
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_base  <= SUM_AW'(r_k * NORD);
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_udone) begin
                        r_pll_mag <= w_ures;
                        r_pll_neg <= r_dot[63];
                        r_ph      <= PH_P2;
                        r_state   <= S_MUL;
                    end
                end
                S_ROOT_R: begin
                    r_state <= S_ROOT_RW;
                end
                S_ROOT_RW: begin
                    if (w_udone) begin
                        r_perp     <= 64'(w_ures[ROOT_W-1:0]);
                        r_q        <= {1'b0, r_olow};
                        r_hi       <= w_hi;
                        r_pq       <= '0;
                        r_mpll     <= ONE_Q32;
                        r_mperp    <= ONE_Q32;
                        r_sat_pll  <= 1'b0;
                        r_sat_perp <= 1'b0;
                        if ({1'b0, r_olow} > w_hi) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                S_ORD: begin
                    // raise both powers up to the current order
                    if (r_pq < r_q) begin
                        r_ph    <= PH_PW;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_pp_s  <= (r_pll_neg && r_q[0]) ? $signed(-r_mpll) : $signed(r_mpll);
                    r_pt_s  <= $signed(r_mperp);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_out_data  <= {6'b0, w_cnt_new, w_new_t, w_new_p, r_q[3:0], w_k_ext[5:0]};
                    r_out_sat   <= r_sat_pll | r_sat_perp | w_ovf_p | w_ovf_t | w_cnt_max;
                    r_out_last  <= (r_q == r_hi);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                        if (r_q == r_hi) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_q     <= r_q + Q_W'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_sat;
    assign o_m_tlast   = r_out_last;
    assign o_cfg_ready = 1'b1;

endmodule
